FILE: design/sgq_pkg.sv
package sgq_pkg;

    // Output level width; the magnitude clamps at 2^(LEVEL_BITS-1)-1.
    localparam int LEVEL_BITS = 16;

    localparam int SAMPLE_W = 32;
    localparam int RND_W    = 32;
    localparam int LC_W     = 15;
    localparam int SCALE_W  = 31;
    localparam int CFG_W    = 31;
    localparam int IDX_W    = 2;

    // |sample| * level span, below 2^47
    localparam int NUM_W   = SAMPLE_W + LC_W;
    // quotient bits kept below saturation
    localparam int Q_W     = LC_W;
    // one overflow compare plus one restoring step per quotient bit
    localparam int DIV_STAGES = Q_W + 1;
    localparam int K_W     = 4;
    // remainder after the leading quotient bit, below scale * 2^14
    localparam int FNUM_W  = SCALE_W + Q_W - 1;
    localparam int PROD_W  = RND_W + SCALE_W;
    localparam int SHAMT_W = 6;

    // accept edge to the edge that takes the result
    localparam int LATENCY = DIV_STAGES + 5;

    localparam logic [LC_W-1:0]  EXP_MAX  = LC_W'(15);
    localparam logic [LC_W:0]    LMAG_MAX = (LC_W+1)'((1 << (LEVEL_BITS - 1)) - 1);

    localparam logic [LC_W-1:0]    LEVEL_COUNT_RST = LC_W'(1);
    localparam logic               NATURAL_RST     = 1'b0;
    localparam logic [SCALE_W-1:0] SCALE_RST       = SCALE_W'(65536);

    typedef enum logic [IDX_W-1:0] {
        REG_LEVEL_COUNT  = 2'd0,
        REG_NATURAL_MODE = 2'd1,
        REG_NORM_SCALE   = 2'd2
    } t_reg_index;

    // Level span L: s in linear mode, 2^(e-1) with e clamped to 1..15 in natural mode.
    function automatic logic [LC_W-1:0] level_span(input logic [LC_W-1:0] lc,
                                                   input logic nat);
        logic [LC_W-1:0] e;
        e = lc;
        if (e < LC_W'(1)) begin
            e = LC_W'(1);
        end
        if (e > EXP_MAX) begin
            e = EXP_MAX;
        end
        return nat ? (LC_W'(1) << (e - LC_W'(1))) : lc;
    endfunction

endpackage

FILE: design/stochastic_gradient_quantizer_unit.sv
// Stochastic gradient quantizer.
// Input: drive i_sample (signed Q16.16), i_random_word and i_last_in with
// start high; the item is taken at a rising edge where start is high and
// busy is low. busy is high only while reset is held, so a new item can be
// taken at every clock edge.
// Output: each item gives one result on o_level / o_last_out, shown for one
// cycle with o_strobe high, in the order the items came in. On its way the
// item passes registers for the absolute value and the |x| * L product, the
// restoring divider stages (an overflow compare and then one quotient bit per
// stage), and registers for the dither product, the rounding compare and the
// final level.
// Throughput is one item per clock; the receiver cannot stall the block.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data
// write level_count (0), natural_mode (1) and norm_scale (2); other indexes
// are dropped. Write only while no item is in flight.
// Reset (synchronous, active low) clears all pipeline valid bits, so every
// item in flight is dropped, and returns the registers to level_count 1,
// linear mode, norm_scale 1.0.
module stochastic_gradient_quantizer_unit import sgq_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    input  logic        [RND_W-1:0]      i_random_word,
    input  logic                         i_last_in,
    output logic                         o_strobe,
    output logic signed [LEVEL_BITS-1:0] o_level,
    output logic                         o_last_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic        [IDX_W-1:0]      i_cfg_index,
    input  logic        [CFG_W-1:0]      i_cfg_data
);

    // One divider stage payload: partial remainder, quotient so far, and the
    // remainder captured right after the leading quotient bit.
    typedef struct packed {
        logic              neg;
        logic              last;
        logic              zero;
        logic              ovf;
        logic [RND_W-1:0]  rnd;
        logic [NUM_W-1:0]  rem;
        logic [Q_W-1:0]    q;
        logic              found;
        logic [K_W-1:0]    k;
        logic [FNUM_W-1:0] fnum;
    } t_div;

    // Configuration registers
    logic [LC_W-1:0]    r_level_count;
    logic               r_natural_mode;
    logic [SCALE_W-1:0] r_norm_scale;
    logic [LC_W-1:0]    lv_span;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign lv_span     = level_span(r_level_count, r_natural_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count  <= LEVEL_COUNT_RST;
            r_natural_mode <= NATURAL_RST;
            r_norm_scale   <= SCALE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LEVEL_COUNT:  r_level_count  <= i_cfg_data[LC_W-1:0];
                REG_NATURAL_MODE: r_natural_mode <= i_cfg_data[0];
                REG_NORM_SCALE:   r_norm_scale   <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: take the item, form the magnitude (2^31 for the most negative
    // sample falls out of the 32-bit negate).
    logic                r_s1_vld;
    logic                r_s1_neg;
    logic                r_s1_last;
    logic                r_s1_zero;
    logic [RND_W-1:0]    r_s1_rnd;
    logic [SAMPLE_W-1:0] r_s1_mag;
    logic [SAMPLE_W-1:0] n_s1_mag;
    logic                accept;

    assign accept   = start & ~busy;
    assign n_s1_mag = i_sample[SAMPLE_W-1] ? (~i_sample + SAMPLE_W'(1)) : i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_neg  <= i_sample[SAMPLE_W-1];
        r_s1_last <= i_last_in;
        r_s1_zero <= (n_s1_mag == '0) || (lv_span == '0);
        r_s1_rnd  <= i_random_word;
        r_s1_mag  <= n_s1_mag;
    end

    // Stage 2 (divider seed): num = |x| * L.
    t_div r_dv     [0:DIV_STAGES];
    t_div n_dv     [0:DIV_STAGES];
    logic r_dv_vld [0:DIV_STAGES];

    always_comb begin
        n_dv[0]       = '0;
        n_dv[0].neg   = r_s1_neg;
        n_dv[0].last  = r_s1_last;
        n_dv[0].zero  = r_s1_zero;
        n_dv[0].rnd   = r_s1_rnd;
        n_dv[0].rem   = NUM_W'(r_s1_mag) * NUM_W'(lv_span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv[0] <= n_dv[0];
    end

    // Restoring divider, one compare/subtract per stage. The first stage only
    // flags a quotient of 2^Q_W or more, which always saturates; a zero scale
    // lands there too.
    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
        localparam int SH = DIV_STAGES - j;
        logic [NUM_W-1:0] trial;

        assign trial = NUM_W'(r_norm_scale) << SH;

        if (j == 1) begin : g_ovf
            always_comb begin
                n_dv[j]     = r_dv[j-1];
                n_dv[j].ovf = r_dv[j-1].rem >= trial;
            end
        end else begin : g_step
            always_comb begin
                n_dv[j] = r_dv[j-1];
                if (r_dv[j-1].rem >= trial) begin
                    n_dv[j].rem   = r_dv[j-1].rem - trial;
                    n_dv[j].q[SH] = 1'b1;
                    if (!r_dv[j-1].found) begin
                        n_dv[j].found = 1'b1;
                        n_dv[j].k     = K_W'(SH);
                        n_dv[j].fnum  = FNUM_W'(r_dv[j-1].rem - trial);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv[j] <= n_dv[j];
        end
    end

    // Post stage 1: saturation test, pick the remainder above the lower
    // candidate, and form random * scale.
    logic               r_p1_vld;
    logic               r_p1_neg;
    logic               r_p1_last;
    logic               r_p1_zero;
    logic               r_p1_sat;
    logic [Q_W-1:0]     r_p1_q;
    logic               r_p1_found;
    logic [K_W-1:0]     r_p1_k;
    logic [FNUM_W-1:0]  r_p1_fnum;
    logic [PROD_W-1:0]  r_p1_prod;
    t_div               dv_end;

    assign dv_end = r_dv[DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= r_dv_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_neg   <= dv_end.neg;
        r_p1_last  <= dv_end.last;
        r_p1_zero  <= dv_end.zero;
        r_p1_sat   <= dv_end.ovf || (dv_end.q >= lv_span);
        r_p1_q     <= dv_end.q;
        r_p1_found <= dv_end.found;
        r_p1_k     <= r_natural_mode ? dv_end.k : '0;
        r_p1_fnum  <= (r_natural_mode && dv_end.found) ? dv_end.fnum
                                                       : FNUM_W'(dv_end.rem);
        r_p1_prod  <= PROD_W'(dv_end.rnd) * PROD_W'(r_norm_scale);
    end

    // Post stage 2: round up when random * scale < fnum * 2^(32-k).
    logic              r_p2_vld;
    logic              r_p2_neg;
    logic              r_p2_last;
    logic              r_p2_zero;
    logic              r_p2_sat;
    logic              r_p2_up;
    logic [LC_W-1:0]   r_p2_lower;
    logic [LC_W-1:0]   r_p2_len;
    logic [SHAMT_W-1:0] shamt;
    logic [PROD_W-1:0]  fnum_sh;
    logic [LC_W-1:0]    pow_k;

    assign shamt   = SHAMT_W'(RND_W) - SHAMT_W'(r_p1_k);
    assign fnum_sh = PROD_W'(r_p1_fnum) << shamt;
    assign pow_k   = LC_W'(1) << r_p1_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_neg  <= r_p1_neg;
        r_p2_last <= r_p1_last;
        r_p2_zero <= r_p1_zero;
        r_p2_sat  <= r_p1_sat;
        r_p2_up   <= r_p1_prod < fnum_sh;
        if (r_natural_mode) begin
            r_p2_lower <= r_p1_found ? pow_k : '0;
            r_p2_len   <= pow_k;
        end else begin
            r_p2_lower <= r_p1_q;
            r_p2_len   <= LC_W'(1);
        end
    end

    // Output stage: add the step, clamp to L and the level range, apply sign.
    logic                         r_strobe;
    logic signed [LEVEL_BITS-1:0] r_level;
    logic                         r_last_out;
    logic [LC_W:0]                mag_sum;
    logic [LC_W:0]                mag;
    logic [LEVEL_BITS-1:0]        mag_t;

    always_comb begin
        mag_sum = (LC_W+1)'(r_p2_lower) + (r_p2_up ? (LC_W+1)'(r_p2_len) : '0);
        mag     = mag_sum;
        if (r_p2_sat || (mag_sum > (LC_W+1)'(lv_span))) begin
            mag = (LC_W+1)'(lv_span);
        end
        if (r_p2_zero) begin
            mag = '0;
        end
        if (mag > LMAG_MAX) begin
            mag = LMAG_MAX;
        end
        mag_t = LEVEL_BITS'(mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level    <= r_p2_neg ? $signed(~mag_t + LEVEL_BITS'(1)) : $signed(mag_t);
        r_last_out <= r_p2_last;
    end

    assign o_strobe   = r_strobe;
    assign o_level    = r_level;
    assign o_last_out = r_last_out;

`ifndef SYNTHESIS
    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    a_zero_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(i_sample == '0, LATENCY) |-> o_level == '0)
        else $error("zero sample gave a nonzero level");

    a_sign_follows_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_level != '0) |->
            o_level[LEVEL_BITS-1] == $past(i_sample[SAMPLE_W-1], LATENCY))
        else $error("level sign differs from sample sign");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_last_out == $past(i_last_in, LATENCY))
        else $error("last mark out of step");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |->
            (o_level[LEVEL_BITS-1] ? (~o_level + 1'b1) : o_level) <= lv_span)
        else $error("level magnitude above the level span");
`endif

endmodule
